// File: design/pam_pkg.sv
// Shared types, codes and defaults for the page allocation map.
package pam_pkg;

	localparam int PAGES_DEF   = 32;
	localparam int ID_BITS_DEF = 8;
	localparam int KB_PER_PAGE = 4;

	// Page count of the largest request: ceil(65535 / 4) needs 15 bits.
	localparam int PGW = 17 - $clog2(KB_PER_PAGE);

	localparam logic [1:0] FN_ADD   = 2'd0;
	localparam logic [1:0] FN_KILL  = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_RUNNING  = 2'd1;
	localparam logic [1:0] STS_NOMEM    = 2'd2;
	localparam logic [1:0] STS_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  program_id;
		logic [15:0] size_kb;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] page_count;
		logic [4:0] start_page;
		logic [4:0] fragment_count;
	} rsp_t;

	typedef struct packed {
		logic take;
		logic issue;
		logic clear_wr;
		logic fill_start;
		logic fill_wr;
		logic load_rsp;
	} cmd_t;

	typedef struct packed {
		logic issue_done;
		logic s1_busy;
		logic fill_ok;
		logic fill_done;
	} sts_t;

endpackage

// File: design/pam_if.sv
// Valid/ready channels for request and response words.
interface pam_req_if;
	logic          valid;
	logic          ready;
	pam_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pam_rsp_if;
	logic          valid;
	logic          ready;
	pam_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/pam_dp.sv
// Datapath: page table memory, scan counter, accumulators and response register.
module pam_dp #(
	parameter int PAGES   = pam_pkg::PAGES_DEF,
	parameter int ID_BITS = pam_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pam_pkg::cmd_t cmd,
	input  pam_pkg::req_t req_data,
	output pam_pkg::sts_t sts,
	output pam_pkg::rsp_t rsp_data
);
	import pam_pkg::*;

	localparam int AW = $clog2(PAGES);
	localparam int CW = $clog2(PAGES + 1);
	localparam int DW = ID_BITS + 1;

	// Each entry holds the used flag on top of the owner id.
	logic [DW-1:0]      mem [PAGES];
	logic [DW-1:0]      mem_rd_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic               rd_vld_s1;

	logic [CW-1:0]      addr_q;
	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic [PGW-1:0]     pages_q;
	logic               found_q;
	logic [CW-1:0]      start_q;
	logic [CW-1:0]      count_q;
	logic               prev_used_q;
	rsp_t               rsp_q;

	logic               s1_used;
	logic               hit;
	logic               cnt_inc;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [DW-1:0]      wr_data;
	logic [15:0]        start_w;
	logic [15:0]        count_w;
	logic [15:0]        fill_end_w;
	logic               fits;
	logic               pages_zero;
	logic [16:0]        kb_sum;
	rsp_t               rsp_next;

	assign s1_used = mem_rd_s1[ID_BITS];
	assign hit     = rd_vld_s1 && s1_used && (mem_rd_s1[ID_BITS-1:0] == id_q);
	assign cnt_inc = rd_vld_s1 && (((op_q == FN_KILL) && hit) ||
		((op_q == FN_QUERY) && (rd_addr_s1 != '0) && prev_used_q && !s1_used));

	assign start_w    = 16'(start_q);
	assign count_w    = 16'(count_q);
	assign fill_end_w = start_w + 16'(pages_q);
	assign fits       = fill_end_w <= 16'(PAGES);
	assign pages_zero = (pages_q == '0);
	assign kb_sum     = 17'(req_data.size_kb) + 17'(KB_PER_PAGE - 1);

	assign sts.issue_done = (addr_q == CW'(PAGES));
	assign sts.s1_busy    = rd_vld_s1;
	assign sts.fill_ok    = (op_q == FN_ADD) && !found_q && !pages_zero && fits;
	assign sts.fill_done  = (16'(addr_q) == fill_end_w);

	// A kill clears the entry read in the previous cycle; clear and fill use the counter.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q[AW-1:0];
		wr_data = '0;
		if (cmd.clear_wr) begin
			wr_en = 1'b1;
		end else if (cmd.fill_wr) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, id_q};
		end else if ((op_q == FN_KILL) && hit) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = {1'b0, mem_rd_s1[ID_BITS-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_s1  <= mem[addr_q[AW-1:0]];
		rd_addr_s1 <= addr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.take) begin
				addr_q <= '0;
			end else if (cmd.fill_start) begin
				addr_q <= start_q;
			end else if (cmd.issue || cmd.clear_wr || cmd.fill_wr) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q        <= req_data.func;
			id_q        <= ID_BITS'(req_data.program_id);
			pages_q     <= PGW'(kb_sum / 17'(KB_PER_PAGE));
			found_q     <= 1'b0;
			start_q     <= '0;
			count_q     <= '0;
			prev_used_q <= 1'b0;
		end else if (rd_vld_s1) begin
			found_q     <= found_q | hit;
			prev_used_q <= s1_used;
			if (s1_used) begin
				start_q <= CW'(rd_addr_s1) + 1'b1;
			end
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		rsp_next = '0;
		case (op_q)
			FN_ADD: begin
				if (found_q) begin
					rsp_next.status = STS_RUNNING;
				end else if (pages_zero) begin
					rsp_next.status = STS_OK;
				end else if (!fits) begin
					rsp_next.status = STS_NOMEM;
				end else begin
					rsp_next.status     = STS_OK;
					rsp_next.page_count = pages_q[5:0];
					rsp_next.start_page = start_w[4:0];
				end
			end
			FN_KILL: begin
				if (count_q == '0) begin
					rsp_next.status = STS_NOTFOUND;
				end else begin
					rsp_next.status     = STS_OK;
					rsp_next.page_count = count_w[5:0];
				end
			end
			FN_QUERY: begin
				rsp_next.status         = STS_OK;
				rsp_next.fragment_count = count_w[4:0];
			end
			default: begin
				rsp_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_data = rsp_q;

endmodule

// File: design/pam_ctrl.sv
// Controller: sequences the clearing pass, table scan, page fill and response.
module pam_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  pam_pkg::sts_t sts,
	output pam_pkg::cmd_t cmd
);
	import pam_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FILL, S_RESULT} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   scan_end;

	assign scan_end  = sts.issue_done && !sts.s1_busy;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:  cmd.clear_wr   = !sts.issue_done;
			S_IDLE:   cmd.take       = req_valid;
			S_SCAN: begin
				cmd.issue      = !sts.issue_done;
				cmd.fill_start = scan_end && sts.fill_ok;
			end
			S_FILL:   cmd.fill_wr    = !sts.fill_done;
			S_RESULT: cmd.load_rsp   = !rsp_valid_q || rsp_ready;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.issue_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= sts.fill_ok ? S_FILL : S_RESULT;
					end
				end
				S_FILL: begin
					if (sts.fill_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					// The previous word must be gone before a new one is loaded.
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/page_allocation_map_core.sv
// Page allocation map: request in, one response word out per request.
// The req channel takes a word {func, program_id, size_kb}: add a program of
// size_kb kilobytes, kill a program, or count fragments. The rsp channel
// returns {status, page_count, start_page, fragment_count} for every request.
// One request is handled at a time. Each request scans the page table once,
// one entry per cycle through the single memory port; an add that allocates
// pages then writes them in a fill pass, and only after that is the response
// word loaded. After reset, a clearing pass marks every page free; req ready
// stays low until it ends. The response sits in an output register: the
// block takes the next request while a response waits, and only stalls at
// the end of that request until the receiver takes the earlier word.
module page_allocation_map_core #(
	parameter int PAGES   = pam_pkg::PAGES_DEF,
	parameter int ID_BITS = pam_pkg::ID_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	pam_req_if.sink   req,
	pam_rsp_if.source rsp
);
	import pam_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pam_dp #(
		.PAGES   (PAGES),
		.ID_BITS (ID_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req.data),
		.sts      (sts),
		.rsp_data (rsp.data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> (!rsp.valid || rsp.ready))
		else $error("response register loaded over a pending word");

	a_one_mem_user: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.fill_wr, cmd.issue}))
		else $error("clear, fill and scan collide on the table port");

endmodule
